[hdl/hrgl_pkg.sv]
// Package with the request types, stage types and constants of the HSV to RGB LED converter.
package hrgl_pkg;

  localparam int unsigned HueSectors = 6;
  localparam int unsigned CompBits   = 8;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned DutyBits   = 2 * CompBits;
  localparam int unsigned H6Bits     = 11;
  localparam int unsigned FBits      = CompBits + 1;
  localparam int unsigned VsfBits    = DutyBits + FBits;

  typedef enum logic [2:0] {
    SecRedYel  = 3'd0,
    SecYelGrn  = 3'd1,
    SecGrnCyan = 3'd2,
    SecCyanBlu = 3'd3,
    SecBluMag  = 3'd4,
    SecMagRed  = 3'd5
  } sector_e;

  typedef struct packed {
    logic                kind;
    logic                led_select;
    logic [CompBits-1:0] hue_or_red;
    logic [CompBits-1:0] sat_or_green;
    logic [CompBits-1:0] value_or_blue;
  } in_req_t;

  typedef struct packed {
    logic                target_led;
    logic [DutyBits-1:0] red_duty;
    logic [DutyBits-1:0] green_duty;
    logic [DutyBits-1:0] blue_duty;
  } out_req_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } stage_en_t;

  typedef struct packed {
    logic                led;
    logic [CompBits-1:0] red;
    logic [CompBits-1:0] green;
    logic [CompBits-1:0] blue;
  } rgb_t;

endpackage

[hdl/hsv_to_rgb_gamma_led.sv]
// Top level of the HSV to RGB converter with gamma squaring for two LEDs.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i/in_stall_o   | in_req_i (in_req_t)
//   out     | output    | out_valid_o/out_stall_i | out_req_o (out_req_t)
//
// A request passes four register stages in order: sector and v*s, p and the interpolation
// product, channel selection, and squaring; the last is the output register. One request
// is accepted per cycle unless a stall backs up to the first stage and raises in_stall_o.
// Reset clears only the stage valid bits. A stall holds a full stage and lets the stages
// before it keep filling any empty slot.
module hsv_to_rgb_gamma_led import hrgl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  logic      v1_q, v2_q, v3_q, v4_q;
  logic      v1_d, v2_d, v3_d, v4_d;
  logic      rdy1, rdy2, rdy3, rdy4;
  stage_en_t ctrl;
  rgb_t      rgb;

  always_comb begin
    rdy4 = !v4_q || !out_stall_i;
    rdy3 = !v3_q || rdy4;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
    ctrl.en1 = rdy1 && in_valid_i;
    ctrl.en2 = rdy2 && v1_q;
    ctrl.en3 = rdy3 && v2_q;
    ctrl.en4 = rdy4 && v3_q;
    v1_d = rdy1 ? in_valid_i : v1_q;
    v2_d = rdy2 ? v1_q : v2_q;
    v3_d = rdy3 ? v2_q : v3_q;
    v4_d = rdy4 ? v3_q : v4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  hrgl_hsv u_hsv (
    .clk_i    (clk_i),
    .in_req_i (in_req_i),
    .ctrl_i   (ctrl),
    .rgb_o    (rgb)
  );

  hrgl_gamma u_gamma (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .rgb_i     (rgb),
    .out_req_o (out_req_o)
  );

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;

`ifndef SYNTH
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> !in_stall_o) else $error("input stalled with an empty first stage");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.red_duty <= 16'd65025) && (out_req_o.green_duty <= 16'd65025)
                    && (out_req_o.blue_duty <= 16'd65025))
    else $error("duty beyond the square of a full component");

  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !(v4_q && out_stall_i)) |=> out_valid_o)
    else $error("request lost between selection and output stage");
`endif

endmodule

[hdl/hrgl_hsv.sv]
// Three pipeline stages that turn an HSV or RGB request into 8-bit red, green and blue.
module hrgl_hsv import hrgl_pkg::*; (
  input  logic      clk_i,
  input  in_req_t   in_req_i,
  input  stage_en_t ctrl_i,
  output rgb_t      rgb_o
);

  logic                kind1_q, led1_q;
  logic [CompBits-1:0] c0_1_q, c1_1_q, c2_1_q;
  logic [DutyBits-1:0] vs1_q, vs1_d;
  sector_e             sec1_q, sec1_d;
  logic [FBits-1:0]    f1_q, f1_d;
  logic [H6Bits-1:0]   h6;
  logic [H6Bits-1:0]   fall;

  always_comb begin
    h6     = H6Bits'(HueSectors) * H6Bits'(in_req_i.hue_or_red);
    sec1_d = sector_e'(h6[H6Bits-1:CompBits]);
    fall   = H6Bits'({h6[H6Bits-1:CompBits] + 3'd1, {CompBits{1'b0}}}) - h6;
    if (h6[CompBits]) begin
      f1_d = FBits'(h6[CompBits-1:0]);
    end else begin
      f1_d = fall[FBits-1:0];
    end
    vs1_d = DutyBits'(in_req_i.value_or_blue) * DutyBits'(in_req_i.sat_or_green);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en1) begin
      kind1_q <= in_req_i.kind;
      led1_q  <= in_req_i.led_select;
      c0_1_q  <= in_req_i.hue_or_red;
      c1_1_q  <= in_req_i.sat_or_green;
      c2_1_q  <= in_req_i.value_or_blue;
      vs1_q   <= vs1_d;
      sec1_q  <= sec1_d;
      f1_q    <= f1_d;
    end
  end

  logic                kind2_q, led2_q;
  logic [CompBits-1:0] c0_2_q, c1_2_q, c2_2_q;
  sector_e             sec2_q;
  logic [CompBits-1:0] p2_q;
  logic [VsfBits-1:0]  vsf2_q;
  logic [DutyBits-1:0] pdiff;

  assign pdiff = {c2_1_q, {CompBits{1'b0}}} - vs1_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en2) begin
      kind2_q <= kind1_q;
      led2_q  <= led1_q;
      c0_2_q  <= c0_1_q;
      c1_2_q  <= c1_1_q;
      c2_2_q  <= c2_1_q;
      sec2_q  <= sec1_q;
      p2_q    <= pdiff[DutyBits-1:CompBits];
      vsf2_q  <= VsfBits'(vs1_q) * VsfBits'(f1_q);
    end
  end

  logic [VsfBits-1:0]  udiff;
  logic [CompBits-1:0] u, v, p;
  rgb_t                rgb_d, rgb_q;

  always_comb begin
    udiff     = VsfBits'({c2_2_q, {FracBits{1'b0}}}) - vsf2_q;
    u         = udiff[FracBits+CompBits-1:FracBits];
    v         = c2_2_q;
    p         = p2_q;
    rgb_d.led = led2_q;
    rgb_d.red   = v;
    rgb_d.green = v;
    rgb_d.blue  = v;
    if (kind2_q) begin
      rgb_d.red   = c0_2_q;
      rgb_d.green = c1_2_q;
      rgb_d.blue  = c2_2_q;
    end else begin
      case (sec2_q)
        SecRedYel: begin
          rgb_d.green = u;
          rgb_d.blue  = p;
        end
        SecYelGrn: begin
          rgb_d.red  = u;
          rgb_d.blue = p;
        end
        SecGrnCyan: begin
          rgb_d.red  = p;
          rgb_d.blue = u;
        end
        SecCyanBlu: begin
          rgb_d.red   = p;
          rgb_d.green = u;
        end
        SecBluMag: begin
          rgb_d.red   = u;
          rgb_d.green = p;
        end
        default: begin
          rgb_d.green = p;
          rgb_d.blue  = u;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en3) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o = rgb_q;

endmodule

[hdl/hrgl_gamma.sv]
// Output stage that squares each color channel into a 16-bit PWM duty.
module hrgl_gamma import hrgl_pkg::*; (
  input  logic      clk_i,
  input  stage_en_t ctrl_i,
  input  rgb_t      rgb_i,
  output out_req_t  out_req_o
);

  out_req_t out_q, out_d;

  always_comb begin
    out_d.target_led = rgb_i.led;
    out_d.red_duty   = DutyBits'(rgb_i.red) * DutyBits'(rgb_i.red);
    out_d.green_duty = DutyBits'(rgb_i.green) * DutyBits'(rgb_i.green);
    out_d.blue_duty  = DutyBits'(rgb_i.blue) * DutyBits'(rgb_i.blue);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en4) begin
      out_q <= out_d;
    end
  end

  assign out_req_o = out_q;

endmodule
